FILE: design/adcb_pkg.sv
package adcb_pkg;

    // hop framing
    localparam int HOP_LENGTH = 256;
    localparam int HOP_POS_W  = 12;

    // register indexes on the configuration port
    localparam logic [1:0] REG_CHANNEL_SELECT = 2'd0;
    localparam logic [1:0] REG_SHIFT_AMOUNT   = 2'd1;
    localparam logic [1:0] REG_SOURCE_MODE    = 2'd2;
    localparam logic [1:0] REG_FILTER_COEFF   = 2'd3;

    // source mode codes
    localparam logic MODE_NORMALIZE = 1'b0;
    localparam logic MODE_DIRECT    = 1'b1;

    // register reset values
    localparam logic        RST_CHANNEL_SELECT = 1'b1;
    localparam logic [4:0]  RST_SHIFT_AMOUNT   = 5'd10;
    localparam logic        RST_SOURCE_MODE    = MODE_NORMALIZE;
    localparam logic [15:0] RST_FILTER_COEFF   = 16'd65023;

    // filter state limits, Q32.16 in 48 bits
    localparam logic signed [47:0] Y_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] Y_MIN = 48'sh8000_0000_0000;

    // normalizing clamp, 131072 in Q32.16
    localparam logic signed [47:0] NORM_LIMIT     = 48'sh0002_0000_0000;
    localparam logic signed [47:0] NORM_LIMIT_NEG = 48'shFFFE_0000_0000;

    typedef struct packed {
        logic        channel_select;
        logic [4:0]  shift_amount;
        logic        source_mode;
        logic [15:0] filter_coeff;
    } t_cfg;

endpackage

FILE: design/adcb_front.sv
module adcb_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  adcb_pkg::t_cfg       i_cfg,
    input  logic                 i_vld,
    input  logic signed [31:0]   i_left,
    input  logic signed [31:0]   i_right,
    output logic                 o_ready,
    output logic                 o_vld,
    output logic signed [31:0]   o_x,
    input  logic                 i_ready
);

    logic               r_vld;
    logic signed [31:0] r_x;
    logic signed [31:0] n_x;

    assign o_ready = !r_vld || i_ready;

    // channel pick and arithmetic shift
    always_comb begin
        n_x = (i_cfg.channel_select ? i_right : i_left) >>> i_cfg.shift_amount;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_vld) begin
            r_x <= n_x;
        end
    end

    assign o_vld = r_vld;
    assign o_x   = r_x;

endmodule

FILE: design/adcb_filter.sv
module adcb_filter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  adcb_pkg::t_cfg       i_cfg,
    input  logic                 i_vld,
    input  logic signed [31:0]   i_x,
    output logic                 o_ready,
    output logic                 o_vld,
    output logic signed [47:0]   o_y,
    input  logic                 i_ready
);

    logic               r_vld;
    logic signed [31:0] r_prev_in;
    logic signed [47:0] r_prev_out;

    logic signed [32:0] diff;
    logic signed [64:0] prod;
    logic signed [47:0] prod_sh;
    logic signed [49:0] sum;
    logic signed [47:0] n_prev_out;

    assign o_ready = !r_vld || i_ready;

    // y = (x - x_prev) * 2^16 + floor(a * y_prev / 2^16), saturated to 48 bits
    always_comb begin
        diff    = {i_x[31], i_x} - {r_prev_in[31], r_prev_in};
        prod    = $signed({1'b0, i_cfg.filter_coeff}) * r_prev_out;
        prod_sh = prod[63:16];
        sum     = {diff[32], diff, 16'b0} + {{2{prod_sh[47]}}, prod_sh};
        if (sum[49:47] == 3'b000 || sum[49:47] == 3'b111) begin
            n_prev_out = sum[47:0];
        end else if (sum[49]) begin
            n_prev_out = adcb_pkg::Y_MIN;
        end else begin
            n_prev_out = adcb_pkg::Y_MAX;
        end
    end

    // filter state doubles as the stage output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_prev_in  <= '0;
            r_prev_out <= '0;
        end else if (o_ready) begin
            r_vld <= i_vld;
            if (i_vld) begin
                r_prev_in  <= i_x;
                r_prev_out <= n_prev_out;
            end
        end
    end

    assign o_vld = r_vld;
    assign o_y   = r_prev_out;

endmodule

FILE: design/adcb_shaper.sv
module adcb_shaper (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  adcb_pkg::t_cfg       i_cfg,
    input  logic                 i_vld,
    input  logic signed [47:0]   i_y,
    output logic                 o_ready,
    output logic                 o_vld,
    output logic signed [15:0]   o_sample,
    output logic                 o_hop_end,
    output logic [14:0]          o_hop_peak,
    input  logic                 i_ready
);

    logic                                 r_vld;
    logic signed [15:0]                   r_sample;
    logic                                 r_hop_end;
    logic [14:0]                          r_hop_peak;
    logic [14:0]                          r_peak;
    logic [adcb_pkg::HOP_POS_W-1:0]       r_hop_pos;

    logic signed [47:0] clip;
    logic signed [49:0] clip_ext;
    logic signed [49:0] scaled;
    logic signed [49:0] scaled_adj;
    logic signed [47:0] direct_adj;
    logic signed [31:0] direct_q;
    logic signed [15:0] n_sample;
    logic [16:0]        abs_s;
    logic [14:0]        mag;
    logic [14:0]        peak_new;
    logic               last;

    assign o_ready = !r_vld || i_ready;

    // normalizing path: clamp, times 32767, truncate toward zero by 2^33
    always_comb begin
        if (i_y > adcb_pkg::NORM_LIMIT) begin
            clip = adcb_pkg::NORM_LIMIT;
        end else if (i_y < adcb_pkg::NORM_LIMIT_NEG) begin
            clip = adcb_pkg::NORM_LIMIT_NEG;
        end else begin
            clip = i_y;
        end
        clip_ext   = {{15{clip[34]}}, clip[34:0]};
        scaled     = (clip_ext <<< 15) - clip_ext;
        scaled_adj = scaled + (scaled[49] ? 50'sh0_0001_FFFF_FFFF : 50'sh0);
    end

    // direct path: truncate toward zero by 2^16, clamp to int16
    always_comb begin
        direct_adj = i_y + (i_y[47] ? 48'sh0000_0000_FFFF : 48'sh0);
        direct_q   = direct_adj[47:16];
    end

    always_comb begin
        unique case (i_cfg.source_mode)
            adcb_pkg::MODE_NORMALIZE: begin
                n_sample = scaled_adj[48:33];
            end
            adcb_pkg::MODE_DIRECT: begin
                if (direct_q > 32'sd32767) begin
                    n_sample = 16'sh7FFF;
                end else if (direct_q < -32'sd32768) begin
                    n_sample = 16'sh8000;
                end else begin
                    n_sample = direct_q[15:0];
                end
            end
            default: begin
                n_sample = '0;
            end
        endcase
    end

    // magnitude and running peak, most negative sample counts as full scale
    always_comb begin
        abs_s    = n_sample[15] ? 17'(-$signed({n_sample[15], n_sample}))
                                : {1'b0, n_sample};
        mag      = (abs_s > 17'd32767) ? 15'h7FFF : abs_s[14:0];
        peak_new = (mag > r_peak) ? mag : r_peak;
        last     = r_hop_pos >= adcb_pkg::HOP_POS_W'(adcb_pkg::HOP_LENGTH - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_peak    <= '0;
            r_hop_pos <= '0;
        end else if (o_ready) begin
            r_vld <= i_vld;
            if (i_vld) begin
                if (last) begin
                    r_peak    <= '0;
                    r_hop_pos <= '0;
                end else begin
                    r_peak    <= peak_new;
                    r_hop_pos <= r_hop_pos + adcb_pkg::HOP_POS_W'(1);
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (o_ready && i_vld) begin
            r_sample   <= n_sample;
            r_hop_end  <= last;
            r_hop_peak <= last ? peak_new : 15'd0;
        end
    end

    assign o_vld      = r_vld;
    assign o_sample   = r_sample;
    assign o_hop_end  = r_hop_end;
    assign o_hop_peak = r_hop_peak;

endmodule

FILE: design/audio_dc_block_conditioner_core.sv
// audio dc-block conditioner
// input stream: one stereo frame per beat, i_s_tdata = {right_word, left_word}.
// output stream: one conditioned sample per beat; o_m_tlast marks the last
// sample of each hop of 256 samples and then o_m_tdata carries the hop peak.
// configuration through the apb port: channel select, shift amount, source
// mode and filter pole; write it only while the stream is idle.
// a frame accepted at the input passes the input register, the filter stage
// and the result register before it shows on the output.
// throughput: one frame per cycle while the receiver does not stall; the
// multiply-accumulate on the filter's previous output is combinational.
// reset (synchronous, active low) empties the pipeline, clears filter state,
// hop position and running peak, and loads the register defaults.
// when the receiver stalls the result holds in the output register, the
// inner stages fill and the input stops taking beats once all are full.
module audio_dc_block_conditioner_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] left_word, [63:32] right_word
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [15:0] sample_out, [30:16] hop_peak, [31] zero
    output logic        o_m_tlast,   // hop_end
    // apb configuration
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    adcb_pkg::t_cfg     r_cfg;
    logic               cfg_we;
    logic [1:0]         cfg_idx;

    logic               x_vld;
    logic               x_ready;
    logic signed [31:0] x_val;
    logic               y_vld;
    logic               y_ready;
    logic signed [47:0] y_val;
    logic signed [15:0] sample;
    logic [14:0]        hop_peak;

    // configuration registers
    assign o_pready = 1'b1;
    assign cfg_we   = i_psel && i_penable && i_pwrite && o_pready;
    assign cfg_idx  = i_paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_select <= adcb_pkg::RST_CHANNEL_SELECT;
            r_cfg.shift_amount   <= adcb_pkg::RST_SHIFT_AMOUNT;
            r_cfg.source_mode    <= adcb_pkg::RST_SOURCE_MODE;
            r_cfg.filter_coeff   <= adcb_pkg::RST_FILTER_COEFF;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                adcb_pkg::REG_CHANNEL_SELECT: r_cfg.channel_select <= i_pwdata[0];
                adcb_pkg::REG_SHIFT_AMOUNT:   r_cfg.shift_amount   <= i_pwdata[4:0];
                adcb_pkg::REG_SOURCE_MODE:    r_cfg.source_mode    <= i_pwdata[0];
                adcb_pkg::REG_FILTER_COEFF:   r_cfg.filter_coeff   <= i_pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (cfg_idx)
            adcb_pkg::REG_CHANNEL_SELECT: o_prdata = {31'b0, r_cfg.channel_select};
            adcb_pkg::REG_SHIFT_AMOUNT:   o_prdata = {27'b0, r_cfg.shift_amount};
            adcb_pkg::REG_SOURCE_MODE:    o_prdata = {31'b0, r_cfg.source_mode};
            adcb_pkg::REG_FILTER_COEFF:   o_prdata = {16'b0, r_cfg.filter_coeff};
            default:                      o_prdata = '0;
        endcase
    end

    // input register with channel pick and shift
    adcb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (i_s_tvalid),
        .i_left  (i_s_tdata[31:0]),
        .i_right (i_s_tdata[63:32]),
        .o_ready (o_s_tready),
        .o_vld   (x_vld),
        .o_x     (x_val),
        .i_ready (x_ready)
    );

    // dc blocking recurrence
    adcb_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (x_vld),
        .i_x     (x_val),
        .o_ready (x_ready),
        .o_vld   (y_vld),
        .o_y     (y_val),
        .i_ready (y_ready)
    );

    // int16 conversion, hop peak and result register
    adcb_shaper u_shaper (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_vld      (y_vld),
        .i_y        (y_val),
        .o_ready    (y_ready),
        .o_vld      (o_m_tvalid),
        .o_sample   (sample),
        .o_hop_end  (o_m_tlast),
        .o_hop_peak (hop_peak),
        .i_ready    (i_m_tready)
    );

    assign o_m_tdata = {1'b0, hop_peak, sample};

    // checks
    a_peak_only_on_hop_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tdata[30:16] == 15'd0)
        else $error("hop peak nonzero outside hop end");

    a_norm_never_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_cfg.source_mode == adcb_pkg::MODE_NORMALIZE
        |-> o_m_tdata[15:0] != 16'h8000)
        else $error("normalized sample reached most negative code");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !y_vld && !x_vld)
        else $error("pipeline not empty after reset");

endmodule
